>>> design/bilinear_image_upscale_assert.svh
// Assertion macros for the bilinear upscaler.
`ifndef BILINEAR_IMAGE_UPSCALE_ASSERT_SVH
`define BILINEAR_IMAGE_UPSCALE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BIL_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bilinear upscaler: same-cycle check failed");
// next-cycle implication
`define BIL_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bilinear upscaler: next-cycle check failed");
`else
`define BIL_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BIL_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> design/bil_pkg.sv
// Shared constants and types of the bilinear upscaler.
`default_nettype none
package bil_pkg;

  // frame store geometry
  localparam int SRC_SIDE     = 256;
  localparam int SRC_AW       = $clog2(SRC_SIDE);
  localparam int ADDR_W       = 2 * SRC_AW;
  localparam int FRAME_DEPTH  = SRC_SIDE * SRC_SIDE;

  // output coordinate range; the coordinate width covers OUT_SIDE_MAX-1 exactly
  localparam int OUT_SIDE_MAX = 4096;
  localparam int COORD_W      = $clog2(OUT_SIDE_MAX);

  localparam int PIX_W        = 8;
  localparam int INV_W        = 17;
  localparam int FRAC_W       = 16;
  localparam int CFG_W        = INV_W;
  localparam int CFG_IDX_W    = 2;

  // shared multiplier operands and accumulator
  localparam int MUL_A_W      = PIX_W + FRAC_W;   // pixel, coordinate or row blend
  localparam int MUL_B_W      = INV_W;            // scale or weight
  localparam int ACC_W        = MUL_A_W + MUL_B_W;

  localparam logic [INV_W-1:0]   INV_RST      = INV_W'(26214);
  localparam logic [COORD_W-1:0] LAST_ROW_RST = COORD_W'(636);
  localparam logic [COORD_W-1:0] LAST_COL_RST = COORD_W'(636);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SCALE = 2'd0,
    REG_LAST_ROW  = 2'd1,
    REG_LAST_COL  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef struct packed {
    logic en;   // update accumulator this cycle
    logic clr;  // start a new sum instead of adding
  } mac_ctl_t;

endpackage
`default_nettype wire

>>> design/bil_frame.sv
// Single-port source frame store with registered read data.
`default_nettype none
module bil_frame (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [bil_pkg::ADDR_W-1:0] addr,
  input  wire logic [bil_pkg::PIX_W-1:0]  wdata,
  output logic      [bil_pkg::PIX_W-1:0]  rdata
);

  logic [bil_pkg::PIX_W-1:0] mem_r [bil_pkg::FRAME_DEPTH];
  logic [bil_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> design/bil_mac.sv
// Shared multiply-accumulate unit.
`default_nettype none
module bil_mac (
  input  wire logic                        clk,
  input  wire bil_pkg::mac_ctl_t           ctl,
  input  wire logic [bil_pkg::MUL_A_W-1:0] a,
  input  wire logic [bil_pkg::MUL_B_W-1:0] b,
  output logic      [bil_pkg::ACC_W-1:0]   acc
);

  logic [bil_pkg::ACC_W-1:0] acc_r;
  logic [bil_pkg::ACC_W-1:0] acc_nxt;
  logic [bil_pkg::ACC_W-1:0] prod;

  assign prod    = bil_pkg::ACC_W'(a) * bil_pkg::ACC_W'(b);
  assign acc_nxt = (ctl.clr ? '0 : acc_r) + prod;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

>>> design/bilinear_image_upscale.sv
// Top level of the bilinear upscaler: config registers, sequencer, output register.
//
// Bilinear upscaler for an 8-bit greyscale image. A load transfer (operation 0)
// writes one pixel into a 256x256 frame store in the cycle it is accepted; loads
// outside the frame are dropped and no load gives a result. A compute transfer
// (operation 1) gives an output row/column; each axis is clamped to last_row /
// last_col, multiplied by inv_scale_q16 (Q16 reciprocal of the scale) and split
// into a source cell (floor) and a 16-bit fraction, with cells at or past the last
// source row/column pinned to the edge. The four neighbours are blended and the
// result is truncated to 8 bits. A compute keeps the input side busy until its result
// enters the output register, and only then can the block take its next item; a finished
// sum waits while the previous result still waits in the output register. The compute
// time comes from the one shared multiply-accumulate unit (two coordinate products plus
// six blend products) and the four reads through the single port of the frame store.
// The output register lets the next item be accepted while a result waits. The
// frame store has no reset and no clearing pass: read only pixels already loaded.
// Configuration writes are taken at once and must happen only while the block is idle.
`default_nettype none
`include "bilinear_image_upscale_assert.svh"
module bilinear_image_upscale (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [bil_pkg::COORD_W-1:0]   in_row,
  input  wire logic [bil_pkg::COORD_W-1:0]   in_col,
  input  wire logic [bil_pkg::PIX_W-1:0]     in_pixel,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [bil_pkg::PIX_W-1:0]     out_pixel,
  // configuration port
  input  wire logic                          cfg_we,
  input  wire logic [bil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bil_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int SRC_AW   = bil_pkg::SRC_AW;
  localparam int COORD_W  = bil_pkg::COORD_W;
  localparam int FRAC_W   = bil_pkg::FRAC_W;
  localparam int PIX_W    = bil_pkg::PIX_W;
  localparam int ACC_W    = bil_pkg::ACC_W;
  localparam int MUL_A_W  = bil_pkg::MUL_A_W;
  localparam int MUL_B_W  = bil_pkg::MUL_B_W;
  localparam int POS_W    = COORD_W + bil_pkg::INV_W;
  localparam int CELL_W   = POS_W - FRAC_W;
  localparam int SUM_SH   = 2 * FRAC_W;            // Q32 sum -> integer
  localparam logic [SRC_AW-1:0] EDGE = SRC_AW'(bil_pkg::SRC_SIDE - 1);

  // One-hot sequencer
  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MROW = 12'b0000_0000_0010,  // row coordinate * scale
    S_MCOL = 12'b0000_0000_0100,  // col coordinate * scale, latch row cell
    S_CSAT = 12'b0000_0000_1000,  // latch col cell
    S_RD0  = 12'b0000_0001_0000,  // read top-left
    S_RD1  = 12'b0000_0010_0000,  // read top-right, blend top-left
    S_RD2  = 12'b0000_0100_0000,  // read bottom-left, blend top-right
    S_RD3  = 12'b0000_1000_0000,  // read bottom-right, save top row, blend bottom-left
    S_RD4  = 12'b0001_0000_0000,  // blend bottom-right
    S_V1   = 12'b0010_0000_0000,  // bottom row * row fraction
    S_V2   = 12'b0100_0000_0000,  // + top row * (1 - row fraction)
    S_DONE = 12'b1000_0000_0000   // saturate into output register
  } state_t;

  typedef struct packed {
    logic [SRC_AW-1:0] base;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  // Floor cell and fraction; pinned to the edge pixel at or past the last source cell.
  function automatic axis_t map_pos(input logic [POS_W-1:0] pos);
    axis_t m;
    if (pos[POS_W-1:FRAC_W] >= CELL_W'(bil_pkg::SRC_SIDE - 1)) begin
      m.base = EDGE;
      m.frac = '0;
    end else begin
      m.base = pos[FRAC_W +: SRC_AW];
      m.frac = pos[FRAC_W-1:0];
    end
    return m;
  endfunction

  state_t state_r, state_nxt;

  // configuration
  logic [bil_pkg::INV_W-1:0] inv_r;
  logic [COORD_W-1:0]        last_row_r;
  logic [COORD_W-1:0]        last_col_r;

  // working registers of one compute
  logic [COORD_W-1:0] rowc_r, colc_r;
  logic [SRC_AW-1:0]  ri_r, ci_r;
  logic [FRAC_W-1:0]  rf_r, cf_r;
  logic [MUL_A_W-1:0] h_r;                 // blended top row
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_pixel_r;

  logic               in_xfer, load_xfer, comp_xfer, out_load;
  logic [COORD_W-1:0] rowc_nxt, colc_nxt;
  logic [SRC_AW-1:0]  r1, c1;
  logic [MUL_B_W-1:0] wr0, wr1, wc0, wc1;
  axis_t              pos_map;

  logic                       mem_we;
  logic [bil_pkg::ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0]           mem_rdata;

  bil_pkg::mac_ctl_t  mac_ctl;
  logic [MUL_A_W-1:0] mac_a;
  logic [MUL_B_W-1:0] mac_b;
  logic [ACC_W-1:0]   acc;
  logic [PIX_W-1:0]   sat_pix;

  // ---------------------------------------------------------------- handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign load_xfer = in_xfer && (in_operation == bil_pkg::OP_LOAD);
  assign comp_xfer = in_xfer && (in_operation == bil_pkg::OP_COMPUTE);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Coordinates past the last interpolated row/column repeat it. The port width
  // already caps them at OUT_SIDE_MAX-1.
  assign rowc_nxt = (in_row > last_row_r) ? last_row_r : in_row;
  assign colc_nxt = (in_col > last_col_r) ? last_col_r : in_col;

  // ---------------------------------------------------------------- config regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r      <= bil_pkg::INV_RST;
      last_row_r <= bil_pkg::LAST_ROW_RST;
      last_col_r <= bil_pkg::LAST_COL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bil_pkg::REG_INV_SCALE: inv_r      <= cfg_wdata;
        bil_pkg::REG_LAST_ROW:  last_row_r <= cfg_wdata[COORD_W-1:0];
        bil_pkg::REG_LAST_COL:  last_col_r <= cfg_wdata[COORD_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (comp_xfer) begin
        state_nxt = S_MROW;
      end
      S_MROW: state_nxt = S_MCOL;
      S_MCOL: state_nxt = S_CSAT;
      S_CSAT: state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_RD4;
      S_RD4:  state_nxt = S_V1;
      S_V1:   state_nxt = S_V2;
      S_V2:   state_nxt = S_DONE;
      S_DONE: if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- axis mapping
  // The accumulator holds coordinate * scale in the cycle after each product.
  assign pos_map = map_pos(acc[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (comp_xfer) begin
      rowc_r <= rowc_nxt;
      colc_r <= colc_nxt;
    end
    if (state_r == S_MCOL) begin
      ri_r <= pos_map.base;
      rf_r <= pos_map.frac;
    end
    if (state_r == S_CSAT) begin
      ci_r <= pos_map.base;
      cf_r <= pos_map.frac;
    end
    if (state_r == S_RD3) begin
      h_r <= acc[MUL_A_W-1:0];
    end
  end

  // far neighbour; the last cell uses the edge pixel itself
  assign r1 = (ri_r == EDGE) ? ri_r : ri_r + SRC_AW'(1);
  assign c1 = (ci_r == EDGE) ? ci_r : ci_r + SRC_AW'(1);

  // Q16 weights: 1 - f and f
  assign wr0 = {1'b1, {FRAC_W{1'b0}}} - {1'b0, rf_r};
  assign wr1 = {1'b0, rf_r};
  assign wc0 = {1'b1, {FRAC_W{1'b0}}} - {1'b0, cf_r};
  assign wc1 = {1'b0, cf_r};

  // ---------------------------------------------------------------- frame store
  always_comb begin
    mem_we   = load_xfer && (in_row < COORD_W'(bil_pkg::SRC_SIDE))
                         && (in_col < COORD_W'(bil_pkg::SRC_SIDE));
    mem_addr = {in_row[SRC_AW-1:0], in_col[SRC_AW-1:0]};
    case (state_r)
      S_RD0:   mem_addr = {ri_r, ci_r};
      S_RD1:   mem_addr = {ri_r, c1};
      S_RD2:   mem_addr = {r1, ci_r};
      S_RD3:   mem_addr = {r1, c1};
      default: ;
    endcase
  end

  bil_frame u_frame (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_pixel),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- shared MAC
  // Columns are blended first (exact, 24 bits per row), then the two rows; the
  // final Q32 sum equals the four-term weighted sum bit for bit.
  always_comb begin
    mac_ctl = '{en: 1'b0, clr: 1'b0};
    mac_a   = '0;
    mac_b   = '0;
    case (state_r)
      S_MROW: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = MUL_A_W'(rowc_r);
        mac_b   = inv_r;
      end
      S_MCOL: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = MUL_A_W'(colc_r);
        mac_b   = inv_r;
      end
      S_RD1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = MUL_A_W'(mem_rdata);
        mac_b   = wc0;
      end
      S_RD2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = MUL_A_W'(mem_rdata);
        mac_b   = wc1;
      end
      S_RD3: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = MUL_A_W'(mem_rdata);
        mac_b   = wc0;
      end
      S_RD4: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = MUL_A_W'(mem_rdata);
        mac_b   = wc1;
      end
      S_V1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1};
        mac_a   = acc[MUL_A_W-1:0];
        mac_b   = wr1;
      end
      S_V2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0};
        mac_a   = h_r;
        mac_b   = wr0;
      end
      default: ;
    endcase
  end

  bil_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // ---------------------------------------------------------------- output
  // Truncate Q32 to integer and saturate to 255.
  assign sat_pix = (|acc[ACC_W-1:SUM_SH+PIX_W]) ? {PIX_W{1'b1}} : acc[SUM_SH +: PIX_W];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_r <= sat_pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  // ---------------------------------------------------------------- checks
  // a compute transfer holds off the input side on the next cycle
  `BIL_ASSERT_NXT(a_comp_busy, clk, rst_n, comp_xfer, !in_ready)
  // a finished result always lands in the output register
  `BIL_ASSERT_NXT(a_done_valid, clk, rst_n, out_load, out_valid && (state_r == S_IDLE))
  // an edge-pinned row cell carries no fraction
  `BIL_ASSERT_IMP(a_edge_frac, clk, rst_n, (state_r == S_RD0) && (ri_r == EDGE), rf_r == '0)

endmodule
`default_nettype wire

>>> tb/sv/bilinear_image_upscale_checker.sv
// Checker for the bilinear upscaler: tracks config and frame, predicts and compares pixels.
module bilinear_image_upscale_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_operation,
  input  logic [bil_pkg::COORD_W-1:0]   in_row,
  input  logic [bil_pkg::COORD_W-1:0]   in_col,
  input  logic [bil_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bil_pkg::PIX_W-1:0]     out_pixel,
  input  logic                          cfg_we,
  input  logic [bil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bil_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bil_pkg::*;

  logic [INV_W-1:0]   scale_recip = INV_RST;
  logic [COORD_W-1:0] row_limit   = LAST_ROW_RST;
  logic [COORD_W-1:0] col_limit   = LAST_COL_RST;
  logic [PIX_W-1:0]   frame_copy [FRAME_DEPTH];
  logic [PIX_W-1:0]   expected_pixels [$];
  logic [PIX_W-1:0]   want;
  int                 fail_count = 0;

  // Output coordinate -> source cell (floor of position) and Q16 fraction.
  function automatic void source_position(input logic [COORD_W-1:0] coord,
                                          input logic [COORD_W-1:0] limit,
                                          output logic [SRC_AW-1:0] base,
                                          output logic [FRAC_W-1:0] frac);
    logic [COORD_W-1:0]       c;
    logic [COORD_W+INV_W-1:0] pos;
    // 12-bit coordinate already sits within OUT_SIDE_MAX-1
    c   = (coord > limit) ? limit : coord;
    pos = c * scale_recip;
    if ((pos >> FRAC_W) >= SRC_SIDE - 1) begin
      base = SRC_AW'(SRC_SIDE - 1);
      frac = '0;
    end else begin
      base = pos[FRAC_W +: SRC_AW];
      frac = pos[FRAC_W-1:0];
    end
  endfunction

  function automatic logic [PIX_W-1:0] bilinear_pixel(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
    logic [SRC_AW-1:0] r0, r1, c0, c1;
    logic [FRAC_W-1:0] rf, cf;
    logic [63:0]       wr0, wr1, wc0, wc1, sum, val;
    source_position(row, row_limit, r0, rf);
    source_position(col, col_limit, c0, cf);
    r1  = (r0 == SRC_SIDE - 1) ? r0 : r0 + 1'b1;
    c1  = (c0 == SRC_SIDE - 1) ? c0 : c0 + 1'b1;
    wr1 = 64'(rf);
    wr0 = 64'd65536 - wr1;
    wc1 = 64'(cf);
    wc0 = 64'd65536 - wc1;
    sum = 64'(frame_copy[{r0, c0}]) * wr0 * wc0
        + 64'(frame_copy[{r1, c0}]) * wr1 * wc0
        + 64'(frame_copy[{r0, c1}]) * wr0 * wc1
        + 64'(frame_copy[{r1, c1}]) * wr1 * wc1;
    val = sum >> 32;
    if (val > 64'd255) val = 64'd255;
    return val[PIX_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_recip = INV_RST;
      row_limit   = LAST_ROW_RST;
      col_limit   = LAST_COL_RST;
      expected_pixels.delete();
    end else begin
      // compare first so a result never meets a prediction made at the same edge
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $error("out_pixel: expected none, got %0d", out_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel !== want) begin
            fail_count++;
            $error("out_pixel: expected %0d, got %0d", want, out_pixel);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_operation == OP_COMPUTE) begin
          expected_pixels.push_back(bilinear_pixel(in_row, in_col));
        end else if (in_row < SRC_SIDE && in_col < SRC_SIDE) begin
          frame_copy[{in_row[SRC_AW-1:0], in_col[SRC_AW-1:0]}] = in_pixel;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INV_SCALE: scale_recip = cfg_wdata[INV_W-1:0];
          REG_LAST_ROW:  row_limit   = cfg_wdata[COORD_W-1:0];
          REG_LAST_COL:  col_limit   = cfg_wdata[COORD_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_pixels.size();
  end

endmodule

>>> tb/sv/tb_bilinear_image_upscale.sv
// Testbench top for the bilinear upscaler: clock, reset, stimulus, watchdog and verdict.
module tb_bilinear_image_upscale;
  timeunit 1ns;
  timeprecision 1ps;
  import bil_pkg::*;

  localparam int PHASE_ITEMS    = 180;   // counted items per config phase
  localparam int SETTLE_CYCLES  = 16;    // covers a full compute plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer or config write

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic                 in_operation = OP_LOAD;
  logic [COORD_W-1:0]   in_row       = '0;
  logic [COORD_W-1:0]   in_col       = '0;
  logic [PIX_W-1:0]     in_pixel     = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_INV_SCALE;
  logic [CFG_W-1:0]     cfg_wdata    = '0;

  int mismatches;
  int outstanding;

  // idling knobs, in percent
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // config currently in force, needed to know which source pixels a compute reads
  int scale_now    = INV_RST;
  int last_row_now = LAST_ROW_RST;
  int last_col_now = LAST_COL_RST;

  // source pixels loaded so far; a compute only goes out once its four neighbours are here
  bit pixel_loaded [FRAME_DEPTH];
  int item_count   = 0;
  int quiet_cycles = 0;

  bilinear_image_upscale dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  bilinear_image_upscale_checker upscale_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel    (out_pixel),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: stalls at random per cycle, so backpressure holds finished results in the output register.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: any transfer or config write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_bilinear_image_upscale: errors");
        $finish;
      end
    end
  end

  // One input transfer. Random sender gaps come first; valid then stays up
  // until the edge where ready is seen high.
  task automatic send_item(input op_t op, input int row, input int col,
                           input logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_row       <= COORD_W'(row);
    in_col       <= COORD_W'(col);
    in_pixel     <= pix;
    do @(posedge clk); while (!in_ready);
  endtask

  // Pixel values lean on the extremes.
  function automatic logic [PIX_W-1:0] any_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Loads outside the frame are dropped by the block and do not count.
  task automatic load_pixel(input int row, input int col, input logic [PIX_W-1:0] pix);
    send_item(OP_LOAD, row, col, pix);
    if (row < SRC_SIDE && col < SRC_SIDE) begin
      pixel_loaded[row * SRC_SIDE + col] = 1'b1;
      item_count++;
    end
  endtask

  // Source cell a compute coordinate lands on, with the edge pinned.
  function automatic int source_cell(input int coord, input int last);
    int c;
    int pos;
    c   = (coord > last) ? last : coord;
    pos = (c * scale_now) / 65536;
    return (pos >= SRC_SIDE - 1) ? SRC_SIDE - 1 : pos;
  endfunction

  // A compute, preceded by loads of any neighbour not yet in the frame store.
  task automatic compute_pixel(input int row, input int col);
    int r0, c0, r, c;
    r0 = source_cell(row, last_row_now);
    c0 = source_cell(col, last_col_now);
    for (int dr = 0; dr < 2; dr++) begin
      for (int dc = 0; dc < 2; dc++) begin
        r = (r0 + dr < SRC_SIDE) ? r0 + dr : r0;
        c = (c0 + dc < SRC_SIDE) ? c0 + dc : c0;
        if (!pixel_loaded[r * SRC_SIDE + c]) load_pixel(r, c, any_pixel());
      end
    end
    // pixel field is ignored on a compute; drive junk anyway
    send_item(OP_COMPUTE, row, col, PIX_W'($urandom_range(0, 255)));
    item_count++;
  endtask

  // Output coordinate: full range, around the last interpolated line, low, or up to it.
  function automatic int pick_coord(input int last);
    int near;
    near = last - 2 + $urandom_range(0, 4);
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, OUT_SIDE_MAX - 1);
      1:       return (near < 0) ? 0 : (near > OUT_SIDE_MAX - 1) ? OUT_SIDE_MAX - 1 : near;
      2:       return $urandom_range(0, (last < 320) ? last : 320);
      default: return $urandom_range(0, last);
    endcase
  endfunction

  // Mostly computes, some overwrites, a few dropped loads outside the frame.
  task automatic random_items(input int quota);
    int target, roll;
    target = item_count + quota;
    while (item_count < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        load_pixel($urandom_range(SRC_SIDE, OUT_SIDE_MAX - 1),
                   $urandom_range(0, OUT_SIDE_MAX - 1), any_pixel());
      end else if (roll < 8) begin
        load_pixel($urandom_range(0, OUT_SIDE_MAX - 1),
                   $urandom_range(SRC_SIDE, OUT_SIDE_MAX - 1), any_pixel());
      end else if (roll < 25) begin
        load_pixel($urandom_range(0, SRC_SIDE - 1), $urandom_range(0, SRC_SIDE - 1),
                   any_pixel());
      end else begin
        compute_pixel(pick_coord(last_row_now), pick_coord(last_col_now));
      end
    end
  endtask

  // Wait until every expected pixel is out, then let a possible trailing item finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
  endtask

  // New config on an idle block, then a burst of random traffic under one idling mode:
  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both at a quarter.
  task automatic run_phase(input int scale, input int lrow, input int lcol, input int mode);
    drain();
    write_reg(REG_INV_SCALE, scale);
    write_reg(REG_LAST_ROW, lrow);
    write_reg(REG_LAST_COL, lcol);
    cfg_we        <= 1'b0;
    scale_now      = scale;
    last_row_now   = lrow;
    last_col_now   = lcol;
    send_idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 25 : 0;
    stall_pct      = (mode == 2) ? 50 : (mode == 3) ? 25 : 0;
    random_items(PHASE_ITEMS);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset config: extreme pixels, dropped loads, overwrite,
    // clamping past the last line, far corners of the coordinate space.
    load_pixel(0, 0, 8'd0);
    load_pixel(0, 1, 8'd255);
    load_pixel(1, 0, 8'd255);
    load_pixel(1, 1, 8'd0);
    load_pixel(OUT_SIDE_MAX - 1, OUT_SIDE_MAX - 1, 8'hAA);
    load_pixel(SRC_SIDE, 3, 8'h55);
    load_pixel(3, SRC_SIDE, 8'h55);
    compute_pixel(0, 0);
    compute_pixel(1, 1);
    load_pixel(0, 0, 8'h5A);
    compute_pixel(1, 1);
    compute_pixel(LAST_ROW_RST, LAST_COL_RST);
    compute_pixel(LAST_ROW_RST + 1, OUT_SIDE_MAX - 1);
    compute_pixel(OUT_SIDE_MAX - 1, 0);
    random_items(PHASE_ITEMS);

    run_phase(65536, 4095, 4095, 1);                 // unit scale, edge pinning
    run_phase(4096, 4095, 4095, 2);                  // 16x upscale, full range
    run_phase(4096, 0, 0, 3);                        // every output repeats line zero
    run_phase(0, 100, 200, 0);                       // zero scale maps all to (0,0)
    run_phase(32768, 511, 300, 1);
    run_phase($urandom_range(4096, 65536), $urandom_range(0, 4095),
              $urandom_range(0, 4095), 2);
    run_phase(65536, 0, 4095, 3);
    run_phase(INV_RST, LAST_ROW_RST, LAST_COL_RST, 0);

    drain();
    if (mismatches == 0) begin
      $display("tb_bilinear_image_upscale: clean");
    end else begin
      $display("tb_bilinear_image_upscale: errors");
    end
    $finish;
  end

endmodule
